### sv/length_prefixed_string_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed string parser
// Shared shorthand for the concurrent checks on the parser ports.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_STRING_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_STRING_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held
`define LPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, switched off while reset is held
`define LPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

### sv/lpsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_pkg
// Types and constants of the length-prefixed string parser.
// ----------------------------------------------------------------------------
package lpsp_pkg;

  localparam int unsigned REG_W      = 29;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned VBN_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  // Largest block size honoured; larger settings are clamped to it
  localparam logic [REG_W-1:0] MAX_BLOCK_BYTES = 29'd268435456;

  localparam logic [BYTE_W-1:0] LOW7          = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT          = 8'h80;
  localparam logic [BYTE_W-1:0] HIGH_IN_FIFTH = 8'h70;
  localparam int unsigned       LAST_SHIFT    = 28;
  localparam logic [VBN_W-1:0]  VARINT_LAST   = 3'd4;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_PAYLOAD,
    PH_STOP,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LENGTH,
    KIND_KEPT,
    KIND_PASSED,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_VARINT_LONG,
    ERR_PAST_END,
    ERR_TRUNCATED
  } err_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES,
    CFG_STRING_COUNT,
    CFG_SKIP_COUNT,
    CFG_LIMIT_COUNT
  } cfg_reg_t;

endpackage
`default_nettype wire

### sv/length_prefixed_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_string_parser
// Splits a byte stream of varint-length-prefixed strings, skips and limits
// strings, and flags block end and malformed lengths.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      slave      one stream byte per transfer
//  out_     master     one result per input byte (kind, byte, index, flags)
//  cfg_     slave      register writes: block size, string count, skip, limit
//
//  One byte is taken per cycle unless a result waits stalled; the parse step
//  of a byte is one level of logic from parser state to the output register.
//  The output register frees in the cycle its result is taken, so in_tready
//  follows out_tready while a result waits.
//  rst_n is synchronous, active low, and clears state, configuration and out_tvalid.
// ----------------------------------------------------------------------------
module length_prefixed_string_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] byte_value
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpsp_pkg::BYTE_W-1:0]         in_tdata,
  // out_tdata: [7:0] data_byte, [36:8] string_index, [37] finished,
  //            [39:38] error_code
  // out_tuser: [1:0] byte_kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [lpsp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpsp_pkg::REG_W-1:0]          cfg_data
);
  import lpsp_pkg::*;

  // configuration
  logic [REG_W-1:0] blk_r, strc_r, skip_r, lim_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic [REG_W-1:0] pos_r, pos_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [VBN_W-1:0] vbn_r, vbn_nxt;
  logic [ACC_W-1:0] pl_r, pl_nxt;
  logic [REG_W-1:0] seen_r, seen_nxt;
  logic [REG_W-1:0] prod_r, prod_nxt;
  err_t             err_r, err_nxt;

  // step terms
  logic             take;
  logic [REG_W-1:0] eff_blk, pos_inc, left;
  logic             at_stop_cur, at_stop_nxt, stop_now, keep;
  logic [ACC_W-1:0] acc_low, acc_fifth, len_val, pl_dec;
  logic             len_done, str_end;

  // result fields
  kind_t            kind_o;
  err_t             errc_o;
  logic             end_o, fin_o;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  assign take      = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r  <= '0;
      strc_r <= '0;
      skip_r <= '0;
      lim_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BLOCK_BYTES:  blk_r  <= cfg_data;
        CFG_STRING_COUNT: strc_r <= cfg_data;
        CFG_SKIP_COUNT:   skip_r <= cfg_data;
        CFG_LIMIT_COUNT:  lim_r  <= cfg_data;
        default:          blk_r  <= blk_r;
      endcase
    end
  end

  // shared terms of the step
  assign eff_blk     = (blk_r > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : blk_r;
  assign pos_inc     = pos_r + 1'b1;
  assign left        = (eff_blk > pos_inc) ? (eff_blk - pos_inc) : '0;
  assign keep        = (seen_r >= skip_r);
  assign at_stop_cur = (phase_r == PH_STOP) ||
                       ((phase_r == PH_LEN) && (vbn_r == '0) &&
                        ((seen_r >= strc_r) || (pos_r >= eff_blk)));
  assign stop_now    = (phase_r != PH_ERR) && at_stop_cur;
  assign pl_dec      = (pl_r != '0) ? (pl_r - 1'b1) : '0;
  assign acc_fifth   = acc_r | {in_tdata[3:0], {LAST_SHIFT{1'b0}}};

  // place the low seven bits by varint byte number
  always_comb begin
    unique case (vbn_r[1:0])
      2'd0:    acc_low = acc_r | {25'd0, in_tdata[6:0]};
      2'd1:    acc_low = acc_r | {18'd0, in_tdata[6:0], 7'd0};
      2'd2:    acc_low = acc_r | {11'd0, in_tdata[6:0], 14'd0};
      default: acc_low = acc_r | {4'd0, in_tdata[6:0], 21'd0};
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    vbn_nxt   = vbn_r;
    pl_nxt    = pl_r;
    seen_nxt  = seen_r;
    prod_nxt  = prod_r;
    err_nxt   = err_r;
    len_val   = acc_low;
    len_done  = 1'b0;
    str_end   = 1'b0;
    if (stop_now) begin
      phase_nxt = PH_STOP;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          pos_nxt = pos_inc;
          if (vbn_r >= VARINT_LAST) begin
            len_val = acc_fifth;
            acc_nxt = acc_fifth;
            if ((in_tdata & (CONT | HIGH_IN_FIFTH)) != '0) begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_VARINT_LONG;
            end else begin
              len_done = 1'b1;
            end
          end else begin
            acc_nxt = acc_low;
            if ((in_tdata & CONT) != '0) begin
              if (pos_inc >= eff_blk) begin
                phase_nxt = PH_ERR;
                err_nxt   = ERR_TRUNCATED;
              end else begin
                vbn_nxt = vbn_r + 1'b1;
              end
            end else begin
              len_done = 1'b1;
            end
          end
          // a complete length opens a string, ends an empty one, stops, or fails
          if (len_done) begin
            acc_nxt = '0;
            vbn_nxt = '0;
            if (len_val > {3'd0, left}) begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_PAST_END;
            end else if (keep && (prod_r >= lim_r)) begin
              phase_nxt = PH_STOP;
            end else if (len_val == '0) begin
              seen_nxt = seen_r + 1'b1;
              if (keep) begin
                prod_nxt = prod_r + 1'b1;
                str_end  = 1'b1;
              end
            end else begin
              pl_nxt    = len_val;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_inc;
          pl_nxt  = pl_dec;
          if (pl_dec == '0) begin
            seen_nxt  = seen_r + 1'b1;
            phase_nxt = PH_LEN;
            if (keep) begin
              prod_nxt = prod_r + 1'b1;
              str_end  = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign at_stop_nxt = (phase_nxt == PH_STOP) ||
                       ((phase_nxt == PH_LEN) && (vbn_nxt == '0) &&
                        ((seen_nxt >= strc_r) || (pos_nxt >= eff_blk)));

  // result fields
  always_comb begin
    if (phase_nxt == PH_ERR) begin
      kind_o = KIND_ERROR;
    end else if (stop_now) begin
      kind_o = KIND_PASSED;
    end else if (phase_r == PH_LEN) begin
      kind_o = KIND_LENGTH;
    end else if (phase_r == PH_PAYLOAD) begin
      kind_o = keep ? KIND_KEPT : KIND_PASSED;
    end else begin
      kind_o = KIND_PASSED;
    end
    end_o  = (phase_nxt != PH_ERR) && str_end;
    fin_o  = (phase_nxt != PH_ERR) && at_stop_nxt;
    errc_o = (phase_nxt == PH_ERR) ? err_nxt : ERR_NONE;
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      pos_r   <= '0;
      acc_r   <= '0;
      vbn_r   <= '0;
      pl_r    <= '0;
      seen_r  <= '0;
      prod_r  <= '0;
      err_r   <= ERR_NONE;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      vbn_r   <= vbn_nxt;
      pl_r    <= pl_nxt;
      seen_r  <= seen_nxt;
      prod_r  <= prod_nxt;
      err_r   <= err_nxt;
    end
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {errc_o, fin_o, seen_r, in_tdata};
      out_user_r <= kind_o;
      out_last_r <= end_o;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### sv/lpsp_checker.sv
`default_nettype none
`include "length_prefixed_string_parser_defines.svh"
// ----------------------------------------------------------------------------
// lpsp_checker
// Port-level checks of the length-prefixed string parser, bound to the top.
// ----------------------------------------------------------------------------
module lpsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [lpsp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import lpsp_pkg::*;

  logic err_kind, has_err;

  assign err_kind = (out_tuser == KIND_ERROR);
  assign has_err  = (out_tdata[39:38] != ERR_NONE);

  // error kind and a non-zero error code always travel together
  `LPSP_ASSERT_NOW(a_err_pair, clk, rst_n, out_tvalid, err_kind == has_err)

  // an errored result is never marked finished nor string end
  `LPSP_ASSERT_NOW(a_err_clean, clk, rst_n, out_tvalid && err_kind,
    !out_tlast && !out_tdata[37])

  // string end only on a length byte or a kept payload byte
  `LPSP_ASSERT_NOW(a_end_kind, clk, rst_n, out_tvalid && out_tlast,
    (out_tuser == KIND_LENGTH) || (out_tuser == KIND_KEPT))

  // a stalled result holds
  `LPSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind length_prefixed_string_parser lpsp_checker u_lpsp_checker (.*);
`default_nettype wire
